// ===== sv/hav_pkg.sv =====
// Shared types, constants and fixed-point helpers for the haversine distance pipeline.
// No dependencies; imported by hav_sincos, haversine_distance and hav_checker.
package hav_pkg;

  typedef logic [30:0]        q30_t;   // unsigned Q30, up to 2^31-1
  typedef logic signed [31:0] sq30_t;  // signed Q30

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef quad_t [3:0] quad4_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [61:0] root;
  } sq_t;

  // payload carried alongside one search step's sin/cos unit
  typedef struct packed {
    q30_t th;
    q30_t cand;
    logic ok;
    q30_t rh;
    q30_t rc;
  } srd_t;

  localparam int SC_LAT     = 7;   // sin/cos unit register stages
  localparam int SQ_STEPS   = 31;  // root bits
  localparam int SR_STEPS   = 31;  // half-angle bits
  localparam int SR_LAT     = SC_LAT + 2;
  localparam int QD_LEN     = SC_LAT + 3;
  localparam int PIPE_DEPTH = 4 + SC_LAT + 4 + SQ_STEPS + SR_STEPS * SR_LAT + 5;

  localparam q30_t PI_HALF    = 31'd1686629713;
  localparam q30_t PI_QUARTER = 31'd843314857;
  localparam q30_t Q30_ONE    = 31'd1073741824;

  localparam logic [25:0] DEG90  = 26'd11796480;
  localparam logic [25:0] DEG180 = 26'd23592960;
  localparam logic [25:0] DEG270 = 26'd35389440;
  localparam logic [26:0] DEG360 = 27'd47185920;

  // remainder to radians: r*PI_HALF/DEG90 = 142*r + r*TRIG_FRAC/(45*2^18)
  localparam logic [7:0]  TRIG_INT  = 8'd142;
  localparam logic [23:0] TRIG_FRAC = 24'd11529553;
  localparam logic [29:0] RECIP45   = 30'd763549742;  // ceil(2^35/45)

  localparam logic [31:0] NM_RECIP = 32'd2374755135;  // floor(2^40/463)
  localparam logic [8:0]  NM_DIV   = 9'd463;
  localparam logic [7:0]  NM_MUL   = 8'd250;
  localparam logic [7:0]  NM_BIAS  = 8'd231;

  localparam logic [23:0] RADIUS_RESET = 24'd1630976;
  localparam logic [2:0]  ADDR_RADIUS  = 3'd0;

  localparam q30_t SIN_K [5] = '{31'd2959, 31'd213043, 31'd8947849, 31'd178956971,
                                 31'd1073741824};
  localparam q30_t COS_K [5] = '{31'd26631, 31'd1491308, 31'd44739243, 31'd536870912,
                                 31'd1073741824};

  // Q30 product of non-negative operands, rounded half up
  function automatic logic [31:0] qmul_u(input q30_t a, input q30_t b);
    logic [62:0] p;
    p = (63'(a) * 63'(b)) + (63'd1 << 29);
    return p[61:30];
  endfunction

  // signed Q30 product, rounded half away from zero
  function automatic sq30_t qmul_s(input sq30_t a, input sq30_t b);
    logic        neg;
    q30_t        ua;
    q30_t        ub;
    logic [31:0] p;
    neg = a[31] ^ b[31];
    ua  = a[31] ? 31'(-a) : a[30:0];
    ub  = b[31] ? 31'(-b) : b[30:0];
    p   = qmul_u(ua, ub);
    return neg ? -$signed(p) : $signed(p);
  endfunction

  function automatic sq30_t quad_sin(input quad_t q, input q30_t s, input q30_t c);
    sq30_t ss;
    sq30_t cc;
    sq30_t r;
    ss = $signed({1'b0, s});
    cc = $signed({1'b0, c});
    case (q)
      QUAD_I:   r = ss;
      QUAD_II:  r = cc;
      QUAD_III: r = -ss;
      default:  r = -cc;
    endcase
    return r;
  endfunction

  function automatic sq30_t quad_cos(input quad_t q, input q30_t s, input q30_t c);
    sq30_t ss;
    sq30_t cc;
    sq30_t r;
    ss = $signed({1'b0, s});
    cc = $signed({1'b0, c});
    case (q)
      QUAD_I:   r = cc;
      QUAD_II:  r = -ss;
      QUAD_III: r = -cc;
      default:  r = ss;
    endcase
    return r;
  endfunction

  // one restoring step of the integer square root, bit weight 2^(60-2*step)
  function automatic sq_t sqrt_step(input sq_t s, input int unsigned step);
    sq_t         o;
    logic [61:0] b;
    logic [62:0] sum;
    b   = 62'd1 << (60 - 2 * step);
    sum = {1'b0, s.root} + {1'b0, b};
    if ({2'b0, s.rem} >= sum) begin
      o.rem  = 61'({2'b0, s.rem} - sum);
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

endpackage

// ===== sv/hav_sincos.sv =====
// Pipelined sin/cos of an angle in [0, pi/2], Q30 radians, seven register stages.
// Taylor polynomials on [0, pi/4], complement with swap above. Uses hav_pkg.
module hav_sincos (
  input  logic         clk,
  input  logic         en,
  input  hav_pkg::q30_t ang_i,
  output hav_pkg::q30_t sin_o,
  output hav_pkg::q30_t cos_o
);
  import hav_pkg::*;

  q30_t        x_r   [6];
  logic        sw_r  [6];
  q30_t        x2_r  [4];
  q30_t        ps_r  [4];
  q30_t        pc_r  [4];
  q30_t        sin_r;
  q30_t        cos_r;
  logic [31:0] x2_w;
  logic [31:0] ms_w  [4];
  logic [31:0] mc_w  [4];
  logic [31:0] sn_w;

  assign x2_w = qmul_u(x_r[0], x_r[0]);
  assign sn_w = qmul_u(x_r[5], ps_r[3]);

  always_comb begin
    ms_w[0] = qmul_u(x2_r[0], SIN_K[0]);
    mc_w[0] = qmul_u(x2_r[0], COS_K[0]);
    for (int k = 1; k < 4; k++) begin
      ms_w[k] = qmul_u(x2_r[k], ps_r[k-1]);
      mc_w[k] = qmul_u(x2_r[k], pc_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fold onto [0, pi/4]
      if (ang_i <= PI_QUARTER) begin
        x_r[0]  <= ang_i;
        sw_r[0] <= 1'b0;
      end else begin
        x_r[0]  <= PI_HALF - ang_i;
        sw_r[0] <= 1'b1;
      end
      for (int s = 1; s < 6; s++) begin
        x_r[s]  <= x_r[s-1];
        sw_r[s] <= sw_r[s-1];
      end
      x2_r[0] <= x2_w[30:0];
      for (int k = 1; k < 4; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      // Horner steps, one product per stage
      for (int k = 0; k < 4; k++) begin
        ps_r[k] <= SIN_K[k+1] - ms_w[k][30:0];
        pc_r[k] <= COS_K[k+1] - mc_w[k][30:0];
      end
      sin_r <= sw_r[5] ? pc_r[3] : sn_w[30:0];
      cos_r <= sw_r[5] ? sn_w[30:0] : pc_r[3];
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== sv/haversine_distance.sv =====
// Haversine great-circle distance, positions in -> nautical miles out, fully pipelined.
// Depends on hav_pkg and hav_sincos.
//
//  port group  | dir | role
//  in_*        | in  | pair of positions, stream slave
//  out_*       | out | distance in nautical miles, stream master
//  cfg_*       | in  | register access, earth radius at address 0
//
// One item per cycle while out_tready does not stall; sections: front trig, haversine sum,
// roots, half-angle search of 31 steps, each step through its own
// sin/cos unit, then scaling and division by 1.852.
// rst_n is synchronous, clears the valid pipeline and loads the default radius.
// Stalls freeze the whole pipeline; in_tready follows out_tready while a result waits.
module haversine_distance (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // lat_a[23:0] lon_a[48:24] lat_b[72:49] lon_b[97:73]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // distance_nm[24:0]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import hav_pkg::*;

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [23:0]           radius_r;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_RADIUS) ? {8'd0, radius_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_RADIUS) begin
      radius_r <= cfg_pwdata[23:0];
    end
  end

  // ---------------- flow control ----------------
  assign adv       = ~vld_r[PIPE_DEPTH-1] | out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  // ---------------- front: angles to quadrant and Q30 radians ----------------
  logic signed [23:0] lat_a_w;
  logic signed [24:0] lon_a_w;
  logic signed [23:0] lat_b_w;
  logic signed [24:0] lon_b_w;
  logic signed [26:0] ang_w [4];

  assign lat_a_w = in_tdata[23:0];
  assign lon_a_w = in_tdata[48:24];
  assign lat_b_w = in_tdata[72:49];
  assign lon_b_w = in_tdata[97:73];

  // differences read as half angles, latitudes doubled for cos(lat)
  assign ang_w[0] = 27'(lat_b_w) - 27'(lat_a_w);
  assign ang_w[1] = 27'(lon_b_w) - 27'(lon_a_w);
  assign ang_w[2] = 27'(lat_a_w) + 27'(lat_a_w);
  assign ang_w[3] = 27'(lat_b_w) + 27'(lat_b_w);

  logic [25:0] ang_r   [4];
  logic [23:0] rem_r   [4];
  logic [28:0] z_r     [4];
  q30_t        r142_r  [4];
  q30_t        t_r     [4];
  quad4_t      qd_r    [QD_LEN];
  quad4_t      quad_w;
  q30_t        s0_w    [4];
  q30_t        c0_w    [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (ang_r[i] >= DEG270)      quad_w[i] = QUAD_IV;
      else if (ang_r[i] >= DEG180) quad_w[i] = QUAD_III;
      else if (ang_r[i] >= DEG90)  quad_w[i] = QUAD_II;
      else                         quad_w[i] = QUAD_I;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        ang_r[i] <= ang_w[i][26] ? 26'(ang_w[i] + DEG360) : ang_w[i][25:0];
        case (quad_w[i])
          QUAD_IV:  rem_r[i] <= 24'(ang_r[i] - DEG270);
          QUAD_III: rem_r[i] <= 24'(ang_r[i] - DEG180);
          QUAD_II:  rem_r[i] <= 24'(ang_r[i] - DEG90);
          default:  rem_r[i] <= ang_r[i][23:0];
        endcase
        z_r[i]    <= 29'((48'(rem_r[i]) * 48'(TRIG_FRAC)) >> 18);
        r142_r[i] <= 31'(31'(rem_r[i]) * 31'(TRIG_INT));
        t_r[i]    <= r142_r[i] + 31'((59'(z_r[i]) * 59'(RECIP45)) >> 35);
      end
      qd_r[0] <= quad_w;
      for (int k = 1; k < QD_LEN; k++) begin
        qd_r[k] <= qd_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_front_sc
    hav_sincos u_sc (
      .clk   (clk),
      .en    (adv),
      .ang_i (t_r[i]),
      .sin_o (s0_w[i]),
      .cos_o (c0_w[i])
    );
  end

  // ---------------- haversine sum ----------------
  sq30_t slat_r;
  sq30_t slon_r;
  sq30_t ca_r;
  sq30_t cb_r;
  sq30_t sa_r;
  sq30_t sl_r;
  sq30_t cc_r;
  sq30_t sa2_r;
  sq30_t t2_r;
  q30_t  hv_r;
  q30_t  hc_r;
  logic signed [32:0] hsum_w;
  q30_t  hclamp_w;

  assign hsum_w   = 33'(sa2_r) + 33'(t2_r);
  assign hclamp_w = hsum_w[32] ? 31'd0 :
                    (hsum_w > 33'(Q30_ONE)) ? Q30_ONE : hsum_w[30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      slat_r <= quad_sin(qd_r[QD_LEN-1][0], s0_w[0], c0_w[0]);
      slon_r <= quad_sin(qd_r[QD_LEN-1][1], s0_w[1], c0_w[1]);
      ca_r   <= quad_cos(qd_r[QD_LEN-1][2], s0_w[2], c0_w[2]);
      cb_r   <= quad_cos(qd_r[QD_LEN-1][3], s0_w[3], c0_w[3]);
      sa_r   <= qmul_s(slat_r, slat_r);
      sl_r   <= qmul_s(slon_r, slon_r);
      cc_r   <= qmul_s(ca_r, cb_r);
      sa2_r  <= sa_r;
      t2_r   <= qmul_s(cc_r, sl_r);
      hv_r   <= hclamp_w;
      hc_r   <= Q30_ONE - hclamp_w;
    end
  end

  // ---------------- square roots, one bit per stage ----------------
  sq_t sqh_in [SQ_STEPS];
  sq_t sqc_in [SQ_STEPS];
  sq_t sqh_r  [SQ_STEPS];
  sq_t sqc_r  [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    if (i == 0) begin : g_first
      assign sqh_in[i] = '{rem: {hv_r, 30'd0}, root: 62'd0};
      assign sqc_in[i] = '{rem: {hc_r, 30'd0}, root: 62'd0};
    end else begin : g_next
      assign sqh_in[i] = sqh_r[i-1];
      assign sqc_in[i] = sqc_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sqh_r[i] <= sqrt_step(sqh_in[i], i);
        sqc_r[i] <= sqrt_step(sqc_in[i], i);
      end
    end
  end

  // ---------------- half-angle search, one bit per step ----------------
  // largest t <= pi/2 with sin(t)*sqrt(1-h) <= cos(t)*sqrt(h)
  q30_t th_in  [SR_STEPS];
  q30_t rh_in  [SR_STEPS];
  q30_t rc_in  [SR_STEPS];
  q30_t th_o_r [SR_STEPS];
  q30_t rh_o_r [SR_STEPS];
  q30_t rc_o_r [SR_STEPS];

  for (genvar j = 0; j < SR_STEPS; j++) begin : g_search
    logic [31:0] cand_w;
    q30_t        sn_w;
    q30_t        cs_w;
    srd_t        dl_r [SC_LAT];
    srd_t        pm_r;
    logic [61:0] pa_r;
    logic [61:0] pb_r;

    if (j == 0) begin : g_first
      assign th_in[j] = 31'd0;
      assign rh_in[j] = sqh_r[SQ_STEPS-1].root[30:0];
      assign rc_in[j] = sqc_r[SQ_STEPS-1].root[30:0];
    end else begin : g_next
      assign th_in[j] = th_o_r[j-1];
      assign rh_in[j] = rh_o_r[j-1];
      assign rc_in[j] = rc_o_r[j-1];
    end

    assign cand_w = {1'b0, th_in[j]} + (32'd1 << (SR_STEPS - 1 - j));

    hav_sincos u_sc (
      .clk   (clk),
      .en    (adv),
      .ang_i (cand_w[30:0]),
      .sin_o (sn_w),
      .cos_o (cs_w)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        dl_r[0] <= '{th: th_in[j], cand: cand_w[30:0], ok: (cand_w[30:0] <= PI_HALF),
                     rh: rh_in[j], rc: rc_in[j]};
        for (int k = 1; k < SC_LAT; k++) begin
          dl_r[k] <= dl_r[k-1];
        end
        pa_r <= 62'(sn_w) * 62'(dl_r[SC_LAT-1].rc);
        pb_r <= 62'(cs_w) * 62'(dl_r[SC_LAT-1].rh);
        pm_r <= dl_r[SC_LAT-1];
        th_o_r[j] <= (pm_r.ok && pa_r <= pb_r) ? pm_r.cand : pm_r.th;
        rh_o_r[j] <= pm_r.rh;
        rc_o_r[j] <= pm_r.rc;
      end
    end
  end

  // ---------------- scale to km, divide by 1.852 ----------------
  logic [25:0] km_r;
  logic [33:0] n_r;
  logic [33:0] n2_r;
  logic [33:0] n3_r;
  logic [48:0] pph_r;
  logic [48:0] ppl_r;
  logic [25:0] q1_r;
  logic [65:0] prod_w;
  logic [34:0] rem_w;
  logic [25:0] nm_w;
  logic [31:0] out_tdata_r;

  assign prod_w = (66'(pph_r) << 17) + 66'(ppl_r);
  assign rem_w  = 35'(n3_r) - 35'(35'(q1_r) * 35'(NM_DIV));
  assign nm_w   = (rem_w >= 35'(NM_DIV)) ? q1_r + 26'd1 : q1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      km_r  <= 26'((57'({th_o_r[SR_STEPS-1], 1'b0}) * 57'(radius_r) + (57'd1 << 29)) >> 30);
      n_r   <= 34'(34'(km_r) * 34'(NM_MUL)) + 34'(NM_BIAS);
      pph_r <= 49'(n_r[33:17]) * 49'(NM_RECIP);
      ppl_r <= 49'(n_r[16:0]) * 49'(NM_RECIP);
      n2_r  <= n_r;
      q1_r  <= prod_w[65:40];
      n3_r  <= n2_r;
      out_tdata_r <= {7'd0, nm_w[24:0]};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

// ===== sv/hav_checker.sv =====
// Port-level checks for haversine_distance, attached by bind.
// Depends on haversine_distance's port list and hav_pkg.
module hav_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata
);
  import hav_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a waiting result blocks new transfers
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline frozen");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // radius written reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_RADIUS
    |=> cfg_paddr != ADDR_RADIUS || cfg_prdata == {8'd0, $past(cfg_pwdata[23:0])})
    else $error("radius readback mismatch");

endmodule

bind haversine_distance hav_checker u_hav_checker (.*);
